/* design/va3_pkg.sv */
// va3_pkg: shared constants and the arctangent table for vector_angle_3d_unit.
// No dependencies.
`timescale 1ns / 1ps
package va3_pkg;
  localparam int unsigned CosFrac     = 30;
  localparam int unsigned CordicSteps = 25;
  localparam int unsigned ZWidth      = 28;
  localparam int unsigned AngWidth    = 18;
  localparam int unsigned ThrWidth    = 16;
  localparam logic [27:0] PiQ24       = 28'd52707179;
  localparam logic [17:0] PiQ16       = 18'd205887;

  function automatic logic [27:0] atan_q24(input logic [4:0] idx);
    logic [27:0] r;
    case (idx)
      5'd0:    r = 28'd13176795;
      5'd1:    r = 28'd7778716;
      5'd2:    r = 28'd4110060;
      5'd3:    r = 28'd2086331;
      5'd4:    r = 28'd1047214;
      5'd5:    r = 28'd524117;
      5'd6:    r = 28'd262123;
      5'd7:    r = 28'd131069;
      default: r = (idx < 5'd25) ? (28'd1 << (5'd24 - idx)) : 28'd0;
    endcase
    return r;
  endfunction
endpackage

/* design/va3_sqrt_stage.sv */
// va3_sqrt_stage: one registered step of a restoring square root, with a side payload.
// Depends on nothing; instantiated by va3_sqrt_pipe.
`timescale 1ns / 1ps
module va3_sqrt_stage #(
  parameter int unsigned RootW = 64,
  parameter int unsigned Bit   = 0,
  parameter int unsigned SideW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [RootW-1:0]   root_i,
  input  logic [2*RootW-1:0] rem_i,
  input  logic [SideW-1:0]   side_i,
  output logic               vld_o,
  output logic [2*RootW-1:0] rad_o,
  output logic [RootW-1:0]   root_o,
  output logic [2*RootW-1:0] rem_o,
  output logic [SideW-1:0]   side_o
);
  // remainder tracks rad - root^2 over the bits examined so far
  logic [2*RootW+1:0] trial;
  logic [2*RootW+1:0] avail;
  logic               vld_q;
  logic [2*RootW-1:0] rad_q, rem_q;
  logic [RootW-1:0]   root_q;
  logic [SideW-1:0]   side_q;

  always_comb begin
    // (2r+2^b)*2^b = cand^2 - r^2
    trial = ({2'b0, {RootW{1'b0}}, root_i} << (Bit + 1))
          + ({{(2*RootW+1){1'b0}}, 1'b1} << (2 * Bit));
    avail = {2'b0, rem_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i;
      side_q <= side_i;
      if (avail >= trial) begin
        root_q <= root_i | (RootW'(1) << Bit);
        rem_q  <= rem_i - trial[2*RootW-1:0];
      end else begin
        root_q <= root_i;
        rem_q  <= rem_i;
      end
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign side_o = side_q;
endmodule

/* design/va3_sqrt_pipe.sv */
// va3_sqrt_pipe: fully pipelined integer square root, one bit per stage.
// Depends on va3_sqrt_stage.
`timescale 1ns / 1ps
module va3_sqrt_pipe #(
  parameter int unsigned RootW = 64,
  parameter int unsigned SideW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               vld_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);
  logic               v   [RootW+1];
  logic [2*RootW-1:0] rad [RootW+1];
  logic [RootW-1:0]   rt  [RootW+1];
  logic [2*RootW-1:0] rm  [RootW+1];
  logic [SideW-1:0]   sd  [RootW+1];

  assign v[0]   = vld_i;
  assign rad[0] = rad_i;
  assign rt[0]  = '0;
  assign rm[0]  = rad_i;
  assign sd[0]  = side_i;

  for (genvar g = 0; g < RootW; g++) begin : g_st
    va3_sqrt_stage #(.RootW(RootW), .Bit(RootW - 1 - g), .SideW(SideW)) u_st (
      .clk_i, .rst_ni, .en_i,
      .vld_i(v[g]), .rad_i(rad[g]), .root_i(rt[g]), .rem_i(rm[g]), .side_i(sd[g]),
      .vld_o(v[g+1]), .rad_o(rad[g+1]), .root_o(rt[g+1]), .rem_o(rm[g+1]),
      .side_o(sd[g+1])
    );
  end

  assign vld_o  = v[RootW];
  assign root_o = rt[RootW];
  assign side_o = sd[RootW];
endmodule

/* design/va3_cordic.sv */
// va3_cordic: pipelined vectoring CORDIC giving atan2(y, x) in Q24, one step per stage.
// Depends on va3_pkg.
`timescale 1ns / 1ps
module va3_cordic #(
  parameter int unsigned XW    = 34,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [XW-1:0]    x_i,
  input  logic [XW-1:0]    y_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic signed [va3_pkg::ZWidth:0] z_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned N = va3_pkg::CordicSteps;
  localparam int unsigned ZW = va3_pkg::ZWidth + 1;

  logic                 v  [N+1];
  logic signed [XW:0]   x  [N+1];
  logic signed [XW:0]   y  [N+1];
  logic signed [ZW-1:0] z  [N+1];
  logic [SideW-1:0]     sd [N+1];

  assign v[0]  = vld_i;
  assign x[0]  = $signed({1'b0, x_i});
  assign y[0]  = $signed({1'b0, y_i});
  assign z[0]  = '0;
  assign sd[0] = side_i;

  for (genvar g = 0; g < N; g++) begin : g_it
    logic signed [XW:0]   dx, dy;
    logic signed [ZW-1:0] at;
    logic                 v_q;
    logic signed [XW:0]   x_q, y_q;
    logic signed [ZW-1:0] z_q;
    logic [SideW-1:0]     sd_q;

    always_comb begin
      // arithmetic shift is floor division by 2^g
      dx = y[g] >>> g;
      dy = x[g] >>> g;
      at = $signed({1'b0, va3_pkg::atan_q24(5'(g))});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q <= sd[g];
        if (!y[g][XW]) begin
          x_q <= x[g] + dx;
          y_q <= y[g] - dy;
          z_q <= z[g] + at;
        end else begin
          x_q <= x[g] - dx;
          y_q <= y[g] + dy;
          z_q <= z[g] - at;
        end
      end
    end

    assign v[g+1]  = v_q;
    assign x[g+1]  = x_q;
    assign y[g+1]  = y_q;
    assign z[g+1]  = z_q;
    assign sd[g+1] = sd_q;
  end

  assign vld_o  = v[N];
  assign z_o    = z[N];
  assign side_o = sd[N];
endmodule

/* design/vector_angle_3d_unit.sv */
// Angle between two 3D vectors, pipelined: one request per cycle sustained while the output stage is not stalled.
// Stages in order: 2 for magnitudes and products + 2 sum stages + (COMP_WIDTH+1) sqrt stages
// + 2 magnitude-product stages + CosFrac+1 divide stages + 1 square stage
// + CosFrac+1 sqrt stages + 25 CORDIC stages + 1 output stage.
// The whole pipe advances together, halting only when the output stage is full and not taken.
// Reset (async, active low) empties the pipe and sets the zero threshold thr_q to 1.
`timescale 1ns / 1ps
module vector_angle_3d_unit #(
  parameter int unsigned COMP_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [va3_pkg::ThrWidth-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COMP_WIDTH-1:0] ax_i,
  input  logic signed [COMP_WIDTH-1:0] ay_i,
  input  logic signed [COMP_WIDTH-1:0] az_i,
  input  logic signed [COMP_WIDTH-1:0] bx_i,
  input  logic signed [COMP_WIDTH-1:0] by_comp_i,
  input  logic signed [COMP_WIDTH-1:0] bz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [va3_pkg::AngWidth-1:0] angle_o,
  output logic                         degenerate_o
);
  localparam int unsigned MW  = COMP_WIDTH;
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned RW  = MW + 1;
  localparam int unsigned DW  = 2 * RW;
  localparam int unsigned CF  = va3_pkg::CosFrac;
  localparam int unsigned QW  = CF + 1;
  localparam int unsigned TW  = va3_pkg::ThrWidth + FRAC_BITS;

  logic en;
  logic ov_q;
  logic [va3_pkg::AngWidth-1:0] ang_q;
  logic deg_q;
  logic [va3_pkg::ThrWidth-1:0] thr_q;

  assign en          = !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= va3_pkg::ThrWidth'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---- stage 1: magnitudes and signs, stage 2: products
  logic [MW-1:0] m1 [6];
  logic [5:0]    n1;
  logic          v1_q, v2_q, v3_q, v4_q;
  logic [MW-1:0] m1_q [6];
  logic [5:0]    n1_q;
  logic [PW-1:0] p2_q [9];
  logic [2:0]    dn2_q;
  logic [SW-1:0] sa3_q, sb3_q;
  logic [SW-1:0] sa4_q, sb4_q, pos4_q, neg4_q;
  logic [SW-1:0] ps3a_q, ps3b_q, ng3a_q, ng3b_q;

  always_comb begin
    m1[0] = ax_i[MW-1] ? MW'(-ax_i) : MW'(ax_i);
    m1[1] = ay_i[MW-1] ? MW'(-ay_i) : MW'(ay_i);
    m1[2] = az_i[MW-1] ? MW'(-az_i) : MW'(az_i);
    m1[3] = bx_i[MW-1] ? MW'(-bx_i) : MW'(bx_i);
    m1[4] = by_comp_i[MW-1] ? MW'(-by_comp_i) : MW'(by_comp_i);
    m1[5] = bz_i[MW-1] ? MW'(-bz_i) : MW'(bz_i);
    n1 = {bz_i[MW-1], by_comp_i[MW-1], bx_i[MW-1], az_i[MW-1], ay_i[MW-1], ax_i[MW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m1;
      n1_q <= n1;
      for (int k = 0; k < 3; k++) begin
        p2_q[k]   <= PW'(m1_q[k]) * PW'(m1_q[k]);
        p2_q[k+3] <= PW'(m1_q[k+3]) * PW'(m1_q[k+3]);
        p2_q[k+6] <= PW'(m1_q[k]) * PW'(m1_q[k+3]);
        dn2_q[k]  <= n1_q[k] ^ n1_q[k+3];
      end
      sa3_q <= SW'(p2_q[0]) + SW'(p2_q[1]) + SW'(p2_q[2]);
      sb3_q <= SW'(p2_q[3]) + SW'(p2_q[4]) + SW'(p2_q[5]);
      ps3a_q <= (dn2_q[0] ? '0 : SW'(p2_q[6])) + (dn2_q[1] ? '0 : SW'(p2_q[7]));
      ps3b_q <= dn2_q[2] ? '0 : SW'(p2_q[8]);
      ng3a_q <= (dn2_q[0] ? SW'(p2_q[6]) : '0) + (dn2_q[1] ? SW'(p2_q[7]) : '0);
      ng3b_q <= dn2_q[2] ? SW'(p2_q[8]) : '0;
      sa4_q  <= sa3_q;
      sb4_q  <= sb3_q;
      pos4_q <= ps3a_q + ps3b_q;
      neg4_q <= ng3a_q + ng3b_q;
    end
  end

  // ---- square roots of both sums, dot halves ride along
  logic          vs;
  logic [RW-1:0] ra, rb;
  logic [2*SW-1:0] dot_s;

  va3_sqrt_pipe #(.RootW(RW), .SideW(2*SW)) u_sqa (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v4_q), .rad_i(DW'(sa4_q)),
    .side_i({pos4_q, neg4_q}), .vld_o(vs), .root_o(ra), .side_o(dot_s)
  );
  va3_sqrt_pipe #(.RootW(RW), .SideW(1)) u_sqb (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v4_q), .rad_i(DW'(sb4_q)),
    .side_i(1'b0), .vld_o(), .root_o(rb), .side_o()
  );

  // ---- magnitude product, dot sign and magnitude
  logic          v5_q, v6_q;
  logic [DW-1:0] den5_q, den6_q;
  logic [SW-1:0] dm5_q, dm6_q;
  logic          dn5_q, dn6_q;
  logic          deg6;
  logic [SW-1:0] pos_s, neg_s;

  assign {pos_s, neg_s} = dot_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= vs;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den5_q <= DW'(ra) * DW'(rb);
      dn5_q  <= pos_s < neg_s;
      dm5_q  <= (pos_s < neg_s) ? neg_s - pos_s : pos_s - neg_s;
      den6_q <= den5_q;
      dn6_q  <= dn5_q;
      dm6_q  <= dm5_q;
    end
  end

  assign deg6 = den6_q < DW'({thr_q, {FRAC_BITS{1'b0}}} & {TW{1'b1}});

  // ---- restoring divide: stage 0 decides the clamp, each later stage gives one quotient bit
  localparam int unsigned RDW = DW + 1;
  logic             dv  [QW+1];
  logic [RDW-1:0]   dr  [QW+1];
  logic [DW-1:0]    dd  [QW+1];
  logic [QW-1:0]    dq  [QW+1];
  logic [2:0]       dsd [QW+1];

  // side: {clamp, degenerate, negative}
  assign dv[0]  = v6_q;
  assign dr[0]  = RDW'(dm6_q);
  assign dd[0]  = den6_q;
  assign dq[0]  = '0;
  assign dsd[0] = {(RDW'(dm6_q) >= RDW'(den6_q)), deg6, dn6_q};

  for (genvar g = 0; g < QW; g++) begin : g_div
    logic           v_q;
    logic [RDW-1:0] r_q;
    logic [DW-1:0]  d_q;
    logic [QW-1:0]  q_q;
    logic [2:0]     s_q;
    logic [RDW-1:0] sh;

    assign sh = dr[g] << 1;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= dv[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q <= dd[g];
        s_q <= dsd[g];
        if (g == 0) begin
          // no-op stage keeps the clamp decision registered
          r_q <= dr[g];
          q_q <= dq[g];
        end else if (sh >= RDW'(dd[g])) begin
          r_q <= sh - RDW'(dd[g]);
          q_q <= {dq[g][QW-2:0], 1'b1};
        end else begin
          r_q <= sh;
          q_q <= {dq[g][QW-2:0], 1'b0};
        end
      end
    end

    assign dv[g+1]  = v_q;
    assign dr[g+1]  = r_q;
    assign dd[g+1]  = d_q;
    assign dq[g+1]  = q_q;
    assign dsd[g+1] = s_q;
  end

  logic [QW-1:0] cmag;
  assign cmag = dsd[QW][2] ? (QW'(1) << CF) : dq[QW];

  // ---- sine: sqrt(2^60 - c^2), square registered first
  logic          v7_q;
  logic [2*QW-1:0] c2_q;
  logic [QW-1:0] cm7_q;
  logic [1:0]    s7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q  <= (2*QW)'((2*QW)'(1) << (2*CF)) - (2*QW)'(cmag) * (2*QW)'(cmag);
      cm7_q <= cmag;
      s7_q  <= dsd[QW][1:0];
    end
  end

  logic          vsn;
  logic [QW-1:0] sinv;
  logic [QW+1:0] sd_sn;

  va3_sqrt_pipe #(.RootW(QW), .SideW(QW+2)) u_sqs (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v7_q), .rad_i(c2_q),
    .side_i({cm7_q, s7_q}), .vld_o(vsn), .root_o(sinv), .side_o(sd_sn)
  );

  // ---- CORDIC
  logic vc;
  logic signed [va3_pkg::ZWidth:0] zc;
  logic [1:0] sc;

  va3_cordic #(.XW(QW + 2), .SideW(2)) u_cor (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vsn),
    .x_i((QW+2)'(sd_sn[QW+1:2])), .y_i((QW+2)'(sinv)), .side_i(sd_sn[1:0]),
    .vld_o(vc), .z_o(zc), .side_o(sc)
  );

  // ---- mirror, round, saturate into the output register
  logic signed [va3_pkg::ZWidth+1:0] ang;
  logic signed [va3_pkg::ZWidth+1:0] qr;
  logic [va3_pkg::AngWidth-1:0] qa;

  always_comb begin
    ang = sc[0] ? ($signed({2'b0, va3_pkg::PiQ24}) - (va3_pkg::ZWidth+2)'(zc))
                : (va3_pkg::ZWidth+2)'(zc);
    if (ang < 0) begin
      ang = '0;
    end
    qr = (ang + 30'sd128) >>> 8;
    qa = (qr > $signed({12'b0, va3_pkg::PiQ16})) ? va3_pkg::PiQ16
                                                 : va3_pkg::AngWidth'(qr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= sc[1];
      ang_q <= sc[1] ? '0 : qa;
    end
  end

  assign out_valid_o  = ov_q;
  assign angle_o      = ang_q;
  assign degenerate_o = deg_q;
endmodule

/* design/va3_checker.sv */
// va3_checker: port-level assertions for vector_angle_3d_unit, bound to the top level.
// Depends on va3_pkg and vector_angle_3d_unit.
`timescale 1ns / 1ps
module va3_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [va3_pkg::AngWidth-1:0] angle_o,
  input logic                         degenerate_o
);
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_o <= va3_pkg::PiQ16) else $error("angle above pi");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> angle_o == '0) else $error("degenerate angle nonzero");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o) else $error("stalled without backpressure");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_o))
    else $error("result dropped");
endmodule

bind vector_angle_3d_unit va3_checker u_va3_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .angle_o, .degenerate_o
);

/* sim/vector_angle_3d_unit_tb.sv */
// Self-checking testbench for vector_angle_3d_unit: random and directed vector pairs,
// bit-exact angle prediction, threshold register sweeps. Depends on va3_pkg and the RTL.
`timescale 1ns / 1ps
module vector_angle_3d_unit_tb;
  localparam int CompW     = 32;
  localparam int DrainWait = 200;
  localparam int IdleLimit = 20000;
  localparam int LongHold  = 600;

  typedef struct {
    logic signed [CompW-1:0] c[6];
  } vec_pair_t;

  typedef struct {
    logic [va3_pkg::AngWidth-1:0] angle;
    logic                         degen;
  } angle_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [va3_pkg::ThrWidth-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [CompW-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [CompW-1:0] bx_i = '0, by_comp_i = '0, bz_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [va3_pkg::AngWidth-1:0] angle_o;
  logic                degenerate_o;

  vector_angle_3d_unit #(.COMP_WIDTH(CompW), .FRAC_BITS(16)) u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .ax_i, .ay_i, .az_i, .bx_i, .by_comp_i, .bz_i,
    .out_valid_o, .out_ready_i, .angle_o, .degenerate_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vec_pair_t     pending_q[$];
  angle_res_t    angle_exp_q[$];
  vec_pair_t     cur_pair;
  logic [15:0]   zero_thr = 16'd1;
  int unsigned   issued = 0, accepted = 0;
  int unsigned   results = 0, degen_seen = 0, mismatches = 0;
  int unsigned   idle_cycles = 0;
  bit            sender_gaps = 1'b0;
  bit            hold_req = 1'b0;

  // arctangent of 2^-i in Q24
  localparam longint AtanTab[25] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1
  };

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  function automatic angle_res_t predict_angle(vec_pair_t p, logic [15:0] thr);
    angle_res_t   res;
    logic [31:0]  mag[6];
    logic [127:0] sa, sb, pos, neg, den, dmag, prod;
    logic [63:0]  cmag, s;
    bit           dneg;
    longint       x, y, z, dx, dy, ang, q;
    sa = '0; sb = '0; pos = '0; neg = '0;
    for (int i = 0; i < 6; i++)
      mag[i] = p.c[i][CompW-1] ? (~p.c[i] + 32'd1) : p.c[i];
    for (int i = 0; i < 3; i++) begin
      sa   += {96'd0, mag[i]} * {96'd0, mag[i]};
      sb   += {96'd0, mag[i+3]} * {96'd0, mag[i+3]};
      prod  = {96'd0, mag[i]} * {96'd0, mag[i+3]};
      if (p.c[i][CompW-1] != p.c[i+3][CompW-1]) neg += prod;
      else pos += prod;
    end
    den = {64'd0, floor_sqrt(sa)} * {64'd0, floor_sqrt(sb)};
    if (den < ({112'd0, thr} << 16)) begin
      res.angle = '0;
      res.degen = 1'b1;
      return res;
    end
    dneg = pos < neg;
    dmag = dneg ? neg - pos : pos - neg;
    if (dmag >= den) cmag = 64'd1 << va3_pkg::CosFrac;
    else cmag = 64'((dmag << va3_pkg::CosFrac) / den);
    s = floor_sqrt({64'd0, (64'd1 << (2 * va3_pkg::CosFrac)) - cmag * cmag});
    x = longint'(cmag);
    y = longint'(s);
    z = 0;
    for (int i = 0; i < va3_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanTab[i];
      end else begin
        x -= dx; y += dy; z -= AtanTab[i];
      end
    end
    ang = dneg ? longint'(va3_pkg::PiQ24) - z : z;
    if (ang < 0) ang = 0;
    q = (ang + 128) >>> 8;
    if (q > longint'(va3_pkg::PiQ16)) q = longint'(va3_pkg::PiQ16);
    res.angle = q[va3_pkg::AngWidth-1:0];
    res.degen = 1'b0;
    return res;
  endfunction

  // component at one of several scales so small and degenerate vectors show up
  function automatic logic signed [CompW-1:0] rand_comp(int scale);
    logic [31:0] r;
    r = $urandom;
    case (scale)
      0: return r;
      1: return {{12{r[19]}}, r[19:0]};
      2: return {{16{r[15]}}, r[15:0]};
      3: return {{24{r[7]}}, r[7:0]};
      default: return (r[1:0] == 0) ? 32'sh8000_0000 :
                      (r[1:0] == 1) ? 32'sh7fff_ffff : 32'sd0;
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t p;
    int        sa, sb;
    int        k;
    sa = $urandom_range(0, 4);
    sb = ($urandom_range(0, 3) == 0) ? sa : $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      p.c[i]   = rand_comp(sa);
      p.c[i+3] = rand_comp(sb);
    end
    k = $urandom_range(0, 9);
    // parallel, antiparallel and swapped-axis pairs push the cosine to its limits
    if (k == 0) for (int i = 0; i < 3; i++) p.c[i+3] = p.c[i];
    else if (k == 1) for (int i = 0; i < 3; i++) p.c[i+3] = -p.c[i];
    else if (k == 2) for (int i = 0; i < 3; i++) p.c[i+3] = p.c[i] >>> $urandom_range(0, 8);
    else if (k == 3) begin
      p.c[3] = -p.c[1]; p.c[4] = p.c[0]; p.c[5] = '0; p.c[2] = '0;
    end
    return p;
  endfunction

  function automatic vec_pair_t mk_pair(longint a0, a1, a2, b0, b1, b2);
    vec_pair_t p;
    p.c[0] = CompW'(a0); p.c[1] = CompW'(a1); p.c[2] = CompW'(a2);
    p.c[3] = CompW'(b0); p.c[4] = CompW'(b1); p.c[5] = CompW'(b2);
    return p;
  endfunction

  task automatic push_directed();
    longint one, mn, mx;
    one = 65536; mn = -64'sd2147483648; mx = 64'sd2147483647;
    pending_q.push_back(mk_pair(0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_pair(0, 0, 0, one, 0, 0));
    pending_q.push_back(mk_pair(one, 0, 0, one, 0, 0));
    pending_q.push_back(mk_pair(one, 0, 0, -one, 0, 0));
    pending_q.push_back(mk_pair(one, 0, 0, 0, one, 0));
    pending_q.push_back(mk_pair(0, 0, one, 0, -one, 0));
    pending_q.push_back(mk_pair(one, one, 0, one, 0, 0));
    pending_q.push_back(mk_pair(-one, -one, 0, one, 0, 0));
    pending_q.push_back(mk_pair(mn, mn, mn, mn, mn, mn));
    pending_q.push_back(mk_pair(mn, mn, mn, mx, mx, mx));
    pending_q.push_back(mk_pair(mx, mx, mx, mx, mx, mx));
    pending_q.push_back(mk_pair(mn, 0, 0, 0, mx, 0));
    pending_q.push_back(mk_pair(mx, mn, mx, mn, mx, mn));
    pending_q.push_back(mk_pair(1, 0, 0, 1, 0, 0));
    pending_q.push_back(mk_pair(255, 0, 0, 0, 255, 0));
    pending_q.push_back(mk_pair(-1, -1, -1, 1, 1, 1));
    pending_q.push_back(mk_pair(mx, 1, 0, mx, 0, 1));
    pending_q.push_back(mk_pair(one, 1, 0, one, -1, 0));
    pending_q.push_back(mk_pair(-1, 0, 0, 0, 0, 0));
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(negedge clk_i);
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    zero_thr = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || issued != accepted || angle_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // sender: bursts with random gaps when sender_gaps is set, valid held until accepted
  int burst_left = 8, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && issued == accepted) begin
      if (sender_gaps && gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_pair = pending_q.pop_front();
        ax_i <= cur_pair.c[0]; ay_i <= cur_pair.c[1]; az_i <= cur_pair.c[2];
        bx_i <= cur_pair.c[3]; by_comp_i <= cur_pair.c[4]; bz_i <= cur_pair.c[5];
        in_valid_i <= 1'b1;
        issued++;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern steps through four modes as rx_cycle advances; one long hold on request
  int unsigned rx_cycle = 0, hold_cnt = 0;
  bit          long_done = 1'b0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req && !long_done) begin
      out_ready_i <= 1'b0;
      if (++hold_cnt >= LongHold) long_done = 1'b1;
    end else begin
      case ((rx_cycle >> 8) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // request capture, result check and watchdog
  always @(posedge clk_i) begin
    angle_res_t exp_r;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        angle_exp_q.push_back(predict_angle(cur_pair, zero_thr));
        accepted++;
        idle_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) idle_cycles = 0;
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        results++;
        if (degenerate_o) degen_seen++;
        if (angle_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: angle=%0d degenerate=%0b", angle_o, degenerate_o);
        end else begin
          exp_r = angle_exp_q.pop_front();
          if (exp_r.angle !== angle_o || exp_r.degen !== degenerate_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp angle=%0d degenerate=%0b got angle=%0d degenerate=%0b",
                       results, exp_r.angle, exp_r.degen, angle_o, degenerate_o);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("vector_angle_3d_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] thr_set[5];
    thr_set = '{16'd1, 16'd0, 16'd65535, 16'd0, 16'd1};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    // threshold 1 after reset
    push_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      thr_set[3] = $urandom_range(1, 65534);
      write_threshold(thr_set[ph]);
      if (ph == 1) push_directed();
      sender_gaps = (ph != 0);
      if (ph == 2) hold_req = 1'b1;
      repeat (230) pending_q.push_back(rand_pair());
      drain();
    end
    if (angle_exp_q.size() != 0) mismatches++;
    $display("covered %0d vector pairs over 6 threshold settings, %0d degenerate results",
             accepted, degen_seen);
    if (mismatches == 0 && results == accepted) begin
      $display("vector_angle_3d_unit_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("vector_angle_3d_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
